/* rtl/core/bltab_pkg.sv */
package bltab_pkg;

	localparam int TableEntriesDef = 16;

	localparam int OpW  = 3;
	localparam int IdW  = 64;
	localparam int StW  = 3;
	localparam int CntW = 32;

	typedef logic [OpW-1:0]  op_t;
	typedef logic [StW-1:0]  st_t;
	typedef logic [IdW-1:0]  id_t;
	typedef logic [CntW-1:0] cnt_t;

	localparam op_t OP_CHECK   = 3'd0;
	localparam op_t OP_BLOCK   = 3'd1;
	localparam op_t OP_UNBLOCK = 3'd2;
	localparam op_t OP_QUERY   = 3'd3;
	localparam op_t OP_CLEAR   = 3'd4;

	localparam st_t ST_OK       = 3'd0;
	localparam st_t ST_DENIED   = 3'd1;
	localparam st_t ST_PRESENT  = 3'd2;
	localparam st_t ST_NOTFOUND = 3'd3;
	localparam st_t ST_FULL     = 3'd4;

	typedef struct packed {
		logic hit;
		logic full;
	} lookup_t;

endpackage

/* rtl/core/bltab_match.sv */
module bltab_match import bltab_pkg::*; #(
	parameter int ENTRIES = TableEntriesDef
) (
	input  logic [ENTRIES-1:0] valid,
	input  id_t                keys [ENTRIES],
	input  id_t                id,
	output logic [ENTRIES-1:0] hit_oh,
	output logic [ENTRIES-1:0] free_oh,
	output lookup_t            look
);

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit_oh[i] = valid[i] && (keys[i] == id);
		end
	end

	// The lowest clear bit of the valid vector is the first free entry.
	assign free_oh   = ~valid & (valid + ENTRIES'(1));
	assign look.hit  = |hit_oh;
	assign look.full = &valid;

endmodule

/* rtl/core/blocklist_table_with_hit_counters.sv */
// An accepted input word is held in stage 1; its result word is registered.
// Throughput: one word per cycle unless out_ready stalls the output; lookup
// and update share stage 1, so back-to-back words see each other's effects.
// Reset clears all entry valid bits and the pipeline valid flags at once;
// keys and counters are left unreset and are only read behind a valid bit.
module blocklist_table_with_hit_counters import bltab_pkg::*; #(
	parameter int TABLE_ENTRIES = TableEntriesDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  op_t  op,
	input  id_t  file_id,
	output logic out_valid,
	input  logic out_ready,
	output st_t  status,
	output cnt_t hit_count
);

	logic                     valid_s1;
	op_t                      op_s1;
	id_t                      id_s1;
	logic                     out_valid_q;
	st_t                      status_q;
	cnt_t                     hit_count_q;

	logic [TABLE_ENTRIES-1:0] entry_valid_q;
	id_t                      entry_key_q   [TABLE_ENTRIES];
	cnt_t                     entry_count_q [TABLE_ENTRIES];

	logic [TABLE_ENTRIES-1:0] hit_oh;
	logic [TABLE_ENTRIES-1:0] free_oh;
	lookup_t                  look;

	logic                     advance;
	logic                     do_s1;
	cnt_t                     sel_count;
	st_t                      status_d;
	cnt_t                     count_d;
	logic [TABLE_ENTRIES-1:0] valid_d;
	logic [TABLE_ENTRIES-1:0] key_we;
	logic [TABLE_ENTRIES-1:0] cnt_inc;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign do_s1    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= op;
			id_s1 <= file_id;
		end
	end

	bltab_match #(
		.ENTRIES(TABLE_ENTRIES)
	) u_match (
		.valid  (entry_valid_q),
		.keys   (entry_key_q),
		.id     (id_s1),
		.hit_oh (hit_oh),
		.free_oh(free_oh),
		.look   (look)
	);

	always_comb begin
		sel_count = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (hit_oh[i]) begin
				sel_count = sel_count | entry_count_q[i];
			end
		end
	end

	always_comb begin
		status_d = ST_OK;
		count_d  = '0;
		valid_d  = entry_valid_q;
		key_we   = '0;
		cnt_inc  = '0;
		unique case (op_s1)
			OP_CHECK: begin
				if (look.hit) begin
					status_d = ST_DENIED;
					cnt_inc  = hit_oh;
				end
			end
			OP_BLOCK: begin
				if (look.hit) begin
					status_d = ST_PRESENT;
				end else if (look.full) begin
					status_d = ST_FULL;
				end else begin
					valid_d = entry_valid_q | free_oh;
					key_we  = free_oh;
				end
			end
			OP_UNBLOCK: begin
				if (look.hit) begin
					valid_d = entry_valid_q & ~hit_oh;
				end else begin
					status_d = ST_NOTFOUND;
				end
			end
			OP_QUERY: begin
				if (look.hit) begin
					count_d = sel_count;
				end else begin
					status_d = ST_NOTFOUND;
				end
			end
			OP_CLEAR: begin
				valid_d = '0;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (do_s1) begin
			entry_valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (do_s1 && key_we[i]) begin
				entry_key_q[i]   <= id_s1;
				entry_count_q[i] <= '0;
			end else if (do_s1 && cnt_inc[i] && !(&entry_count_q[i])) begin
				entry_count_q[i] <= entry_count_q[i] + cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_s1) begin
			status_q    <= status_d;
			hit_count_q <= count_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign hit_count = hit_count_q;

`ifndef SYNTHESIS
	// Keys are unique, so at most one entry can match.
	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(hit_oh))
		else $error("more than one table entry matches the identifier");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(do_s1 && op_s1 == OP_CLEAR) |=> (entry_valid_q == '0))
		else $error("table not empty after a clear");

	a_count_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (hit_count_q == '0))
		else $error("non-zero hit count with a failing status");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(do_s1 && status_d == ST_FULL) |-> (&entry_valid_q))
		else $error("table full reported with a free entry");
`endif

endmodule
